/* hdl/mailbox_wildcard_matcher_defines.svh */
// Assertion macros shared by the mailbox wildcard matcher RTL.
`ifndef MAILBOX_WILDCARD_MATCHER_DEFINES_SVH
`define MAILBOX_WILDCARD_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MWM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MWM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mwm_pkg.sv */
// Types, constants and helper functions of the mailbox wildcard matcher.
`timescale 1ns / 1ps

package mwm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int NPOS        = MAX_PATTERN + 1;
  localparam int POS_W       = $clog2(NPOS);

  localparam int BYTE_W      = 8;
  localparam int ACTION_W    = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Register index as seen in paddr[2].
  localparam logic REG_DELIMITER = 1'b0;

  localparam logic [BYTE_W-1:0] STAR_BYTE    = 8'h2A;
  localparam logic [BYTE_W-1:0] PERCENT_BYTE = 8'h25;
  localparam logic [BYTE_W-1:0] DELIM_RESET  = 8'h7C;
  localparam logic [BYTE_W-1:0] UPPER_A      = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z      = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [ACTION_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] value;
    logic              wild;
    logic              star;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_slot_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

/* hdl/mwm_ifs.sv */
// Request and result channel interfaces of the mailbox wildcard matcher.
`timescale 1ns / 1ps

interface mwm_req_if import mwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   byte_value;

  modport source (output valid, action, byte_value, input ready);
  modport sink   (input valid, action, byte_value, output ready);
endinterface

interface mwm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, matched, pattern_overflow, input ready);
  modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

/* hdl/mailbox_wildcard_matcher.sv */
// Top level of the mailbox wildcard matcher with its register port.
`timescale 1ns / 1ps

// Case-insensitive mailbox pattern matcher. Load a pattern with a clear
// request followed by append requests, then stream name bytes and finish
// each name with an end request, which returns one result (matched and
// pattern_overflow). '*' matches any run, '%' any run without the
// hierarchy delimiter (register at address 0, reset '|'). One request is
// taken every clock cycle while the queue is not full; every pattern cell
// updates from a name byte at once in the matching engine. A four-entry
// queue sits between the request port and the engine, and an end
// request's result is registered by the engine once it leaves the queue.
// Only a result left waiting on the output holds up further end requests;
// the queue absorbs up to four requests behind it. Appends beyond 64 bytes
// set the overflow flag until the next clear.
module mailbox_wildcard_matcher import mwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mwm_req_if.sink               req,
  mwm_res_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [BYTE_W-1:0] delimiter;
  q_slot_t           push;
  q_slot_t           head;
  logic              full;
  logic              pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DELIMITER) begin
      delimiter <= pwdata[BYTE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DELIMITER) begin
      prdata = CFG_DATA_W'(delimiter);
    end
  end

  mwm_front u_front (
    .req  (req),
    .full (full),
    .push (push)
  );

  mwm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  mwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .delimiter (delimiter),
    .rsp       (rsp)
  );

endmodule

/* hdl/mwm_front.sv */
// Front end: accepts requests, folds case and classifies wildcard bytes.
`timescale 1ns / 1ps

module mwm_front import mwm_pkg::*; (
  mwm_req_if.sink  req,
  input  logic     full,
  output q_slot_t  push
);

  logic [BYTE_W-1:0] folded;

  assign folded   = fold_byte(req.byte_value);
  assign req.ready = ~full;

  always_comb begin
    push.valid     = req.valid;
    push.cmd.op    = op_t'(req.action);
    push.cmd.value = folded;
    push.cmd.star  = (folded == STAR_BYTE);
    push.cmd.wild  = (folded == STAR_BYTE) || (folded == PERCENT_BYTE);
  end

endmodule

/* hdl/mwm_queue.sv */
// Short command queue between the front end and the matching engine.
`timescale 1ns / 1ps

module mwm_queue import mwm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_slot_t push,
  output logic    full,
  output q_slot_t head,
  input  logic    pop
);

  cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W:0] wr_ptr;
  logic [QPTR_W:0] rd_ptr;
  logic          empty;
  logic          do_push;
  logic          do_pop;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[QPTR_W] != rd_ptr[QPTR_W]) &&
                 (wr_ptr[QPTR_W-1:0] == rd_ptr[QPTR_W-1:0]);

  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  assign head.valid = ~empty;
  assign head.cmd   = entries[rd_ptr[QPTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr[QPTR_W-1:0]] <= push.cmd;
    end
  end

endmodule

/* hdl/mwm_back.sv */
// Matching engine: pattern cells, position set update and result register.
`timescale 1ns / 1ps
`include "mailbox_wildcard_matcher_defines.svh"

module mwm_back import mwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  q_slot_t           head,
  output logic              pop,
  input  logic [BYTE_W-1:0] delimiter,
  mwm_res_if.source         rsp
);

  logic [BYTE_W-1:0]      pat [MAX_PATTERN];
  logic [POS_W-1:0]       len;
  logic                   overflow;
  logic [NPOS-1:0]        active;
  logic [MAX_PATTERN-1:0] wild;
  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] trail;
  logic                   run_star;

  logic [NPOS-1:0]        g_lvl [POS_W+1];
  logic [NPOS-1:0]        p_lvl [POS_W+1];
  logic [NPOS-1:0]        closed;
  logic [NPOS-1:0]        active_next;
  logic [NPOS-1:0]        reach;
  logic [MAX_PATTERN-1:0] filled;
  logic [MAX_PATTERN-1:0] tail_sel;
  logic [MAX_PATTERN-1:0] trail_next;
  logic                   run_star_next;
  logic                   can_append;
  logic [BYTE_W-1:0]      delim_f;
  logic                   is_end;

  assign delim_f    = fold_byte(delimiter);
  assign can_append = (len < POS_W'(MAX_PATTERN));
  assign is_end     = (head.cmd.op == OP_END);
  assign pop        = head.valid && (!is_end || !rsp.valid || rsp.ready);
  assign reach      = {filled, 1'b1};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      filled[i]   = (POS_W'(i) < len);
      tail_sel[i] = (len == POS_W'(i));
    end
  end

  // A wildcard can match nothing, so activity spreads through runs of
  // wildcards. A log-depth prefix scan does this in parallel.
  always_comb begin
    g_lvl[0] = active;
    p_lvl[0] = {wild, 1'b0};
    for (int l = 0; l < POS_W; l++) begin
      for (int j = 0; j < NPOS; j++) begin
        if (j >= (1 << l)) begin
          g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j - (1 << l)]);
          p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j - (1 << l)];
        end else begin
          g_lvl[l+1][j] = g_lvl[l][j];
          p_lvl[l+1][j] = 1'b0;
        end
      end
    end
    closed = g_lvl[POS_W];
  end

  // Every pattern cell looks at the name byte at once.
  always_comb begin
    active_next = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (closed[i] && wild[i] && (star[i] || head.cmd.value != delim_f)) begin
        active_next[i] = 1'b1;
      end
      if (closed[i] && filled[i] && !wild[i] && pat[i] == head.cmd.value) begin
        active_next[i+1] = 1'b1;
      end
    end
  end

  // A wildcard run behaves as a star run as soon as any member is a star,
  // so the whole trailing run is updated when a star joins it.
  always_comb begin
    run_star_next = ((|trail) & run_star) | head.cmd.star;
    trail_next    = head.cmd.wild ? (trail | tail_sel) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      overflow  <= 1'b0;
      active    <= NPOS'(1);
      wild      <= '0;
      star      <= '0;
      trail     <= '0;
      run_star  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (pop && is_end) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (pop) begin
        case (head.cmd.op)
          OP_CLEAR: begin
            len      <= '0;
            overflow <= 1'b0;
            active   <= NPOS'(1);
            wild     <= '0;
            star     <= '0;
            trail    <= '0;
            run_star <= 1'b0;
          end
          OP_APPEND: begin
            if (can_append) begin
              len      <= len + 1'b1;
              wild     <= wild | (head.cmd.wild ? tail_sel : '0);
              trail    <= trail_next;
              run_star <= head.cmd.wild & run_star_next;
              if (head.cmd.wild && run_star_next) begin
                star <= star | trail_next;
              end
            end else begin
              overflow <= 1'b1;
            end
            active <= NPOS'(1);
          end
          OP_NAME: begin
            active <= active_next;
          end
          OP_END: begin
            active <= NPOS'(1);
          end
          default: begin
            active <= active;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_end) begin
      rsp.matched          <= closed[len] & ~overflow;
      rsp.pattern_overflow <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.cmd.op == OP_APPEND && can_append) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (tail_sel[i]) begin
          pat[i] <= head.cmd.value;
        end
      end
    end
  end

  `MWM_ASSERT_IMP(a_active_in_range, clk, rst, 1'b1, (active & ~reach) == '0, "active position beyond pattern end")
  `MWM_ASSERT_IMP(a_overflow_full, clk, rst, overflow, len == POS_W'(MAX_PATTERN), "overflow with store not full")
  `MWM_ASSERT_IMP(a_overflow_no_match, clk, rst, rsp.valid && rsp.pattern_overflow, !rsp.matched, "match reported on overflowed pattern")
  `MWM_ASSERT_IMP(a_star_is_wild, clk, rst, 1'b1, (star & ~wild) == '0, "star run flag on a literal cell")
  `MWM_ASSERT_NXT(a_end_restarts, clk, rst, pop && is_end, active == NPOS'(1), "position set not restarted after end of name")

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the mailbox wildcard matcher.
`timescale 1ns / 1ps

module testbench import mwm_pkg::*;;

  localparam int RANDOM_ITEMS  = 1880;
  localparam int SEGMENTS      = 6;
  localparam int HOLD_SEGMENT  = 4;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_NAME      = 24;
  localparam logic [CFG_ADDR_W-1:0] DELIM_ADDR = {REG_DELIMITER, 2'b00};

  typedef struct {
    logic matched;
    logic overflow;
  } match_verdict_t;

  // Bit-parallel copy of the matcher: one flag per pattern position.
  class match_predictor;
    logic [BYTE_W-1:0] delim;
    logic [BYTE_W-1:0] pat [MAX_PATTERN];
    int                plen;
    bit   [NPOS-1:0]   live;
    bit                ovf;
    bit                star_like [MAX_PATTERN];
    match_verdict_t    expected_verdicts[$];

    function new();
      delim = DELIM_RESET;
      plen  = 0;
      ovf   = 0;
      live  = NPOS'(1);
    endfunction

    function logic [BYTE_W-1:0] lower(logic [BYTE_W-1:0] c);
      if (c >= UPPER_A && c <= UPPER_Z) begin
        return c + CASE_OFFSET;
      end
      return c;
    endfunction

    function bit is_wc(logic [BYTE_W-1:0] c);
      return c == STAR_BYTE || c == PERCENT_BYTE;
    endfunction

    // A run of wildcards behaves as a star when any member is a star.
    function void classify();
      int i;
      for (i = 0; i < plen; i++) begin
        star_like[i] = is_wc(pat[i]) && (pat[i] == STAR_BYTE ||
                       (i > 0 && is_wc(pat[i-1]) && star_like[i-1]));
      end
      for (i = plen; i >= 2; i--) begin
        if (is_wc(pat[i-2]) && is_wc(pat[i-1]) && star_like[i-1]) begin
          star_like[i-2] = 1;
        end
      end
    endfunction

    // Wildcards may match nothing, so activity ripples past them.
    function void spread();
      int i;
      for (i = 0; i < plen; i++) begin
        if (live[i] && is_wc(pat[i])) begin
          live[i+1] = 1;
        end
      end
    endfunction

    function void step_name(logic [BYTE_W-1:0] c);
      bit [NPOS-1:0]     nxt;
      logic [BYTE_W-1:0] d;
      int                i;
      d = lower(delim);
      classify();
      spread();
      nxt = '0;
      for (i = 0; i < plen; i++) begin
        if (live[i]) begin
          if (is_wc(pat[i])) begin
            if (star_like[i] || c != d) begin
              nxt[i] = 1;
            end
          end else if (pat[i] == c) begin
            nxt[i+1] = 1;
          end
        end
      end
      live = nxt;
    endfunction

    function void note_request(op_t op, logic [BYTE_W-1:0] b);
      match_verdict_t v;
      logic [BYTE_W-1:0] c;
      c = lower(b);
      case (op)
        OP_CLEAR: begin
          plen = 0;
          ovf  = 0;
          live = NPOS'(1);
        end
        OP_APPEND: begin
          if (plen < MAX_PATTERN) begin
            pat[plen] = c;
            plen++;
          end else begin
            ovf = 1;
          end
          live = NPOS'(1);
        end
        OP_NAME: begin
          step_name(c);
        end
        default: begin
          spread();
          v.matched  = live[plen] && !ovf;
          v.overflow = ovf;
          expected_verdicts.push_back(v);
          live = NPOS'(1);
        end
      endcase
    endfunction

    function string check_verdict(logic m, logic o);
      match_verdict_t want;
      string note;
      if (expected_verdicts.size() == 0) begin
        return $sformatf("unexpected result matched=%b overflow=%b", m, o);
      end
      want = expected_verdicts.pop_front();
      note = "";
      if (m !== want.matched) begin
        note = $sformatf("matched %b, expected %b", m, want.matched);
      end
      if (o !== want.overflow) begin
        note = {note, $sformatf(" pattern_overflow %b, expected %b", o, want.overflow)};
      end
      return note;
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mwm_req_if req_bus ();
  mwm_res_if rsp_bus ();

  mailbox_wildcard_matcher u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  match_predictor    predictor = new();
  int                errors = 0;
  int                sent = 0;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  bit                stall_armed = 0;
  bit                rx_hold = 0;
  logic [BYTE_W-1:0] cur_delim = DELIM_RESET;
  logic [BYTE_W-1:0] pattern_bytes[$];
  string             verdict_note;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      verdict_note = predictor.check_verdict(rsp_bus.matched, rsp_bus.pattern_overflow);
      if (verdict_note != "") begin
        report_mismatch(verdict_note);
      end
    end
  end

  // Result side: random back-pressure, plus a long hold when armed.
  initial begin
    rsp_bus.ready = 0;
    forever begin
      @(negedge clk);
      rsp_bus.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    @(posedge stall_armed);
    rx_hold = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 0;
  end

  task automatic send_req(input op_t op, input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_bus.valid      <= 0;
      req_bus.action     <= ACTION_W'($urandom_range(3));
      req_bus.byte_value <= BYTE_W'($urandom_range(255));
      @(negedge clk);
    end
    req_bus.valid      <= 1;
    req_bus.action     <= op;
    req_bus.byte_value <= b;
    do @(posedge clk); while (!req_bus.ready);
    predictor.note_request(op, b);
    sent++;
    if (op == OP_CLEAR) begin
      pattern_bytes.delete();
    end else if (op == OP_APPEND) begin
      pattern_bytes.push_back(b);
    end
  endtask

  // Stop sending, wait for every result, then let the queue run dry.
  task automatic drain();
    @(negedge clk);
    req_bus.valid <= 0;
    while (predictor.expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_delimiter(input logic [BYTE_W-1:0] value);
    @(negedge clk);
    psel    <= 1;
    pwrite  <= 1;
    penable <= 0;
    paddr   <= DELIM_ADDR;
    pwdata  <= {(CFG_DATA_W - BYTE_W)'($urandom), value};
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    predictor.delim = value;
    cur_delim = value;
    // Read the register back in the next transfer.
    @(negedge clk);
    pwrite  <= 0;
    penable <= 0;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    if (prdata[BYTE_W-1:0] !== value) begin
      report_mismatch($sformatf("delimiter read %h, expected %h", prdata[BYTE_W-1:0], value));
    end
    @(negedge clk);
    psel    <= 0;
    penable <= 0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(11))
      0:       return "a";
      1:       return "b";
      2:       return "A";
      3:       return "B";
      4:       return cur_delim;
      5:       return STAR_BYTE;
      6:       return PERCENT_BYTE;
      7:       return 8'h00;
      8:       return "/";
      9:       return DELIM_RESET;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] swap_case(logic [BYTE_W-1:0] c);
    if (c >= UPPER_A + CASE_OFFSET && c <= UPPER_Z + CASE_OFFSET) begin
      return c - CASE_OFFSET;
    end
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // Builds a name that mostly follows the current pattern, with some damage.
  task automatic send_name();
    int                produced;
    int                r;
    logic [BYTE_W-1:0] b;
    produced = 0;
    foreach (pattern_bytes[i]) begin
      if (produced >= MAX_NAME) break;
      b = pattern_bytes[i];
      if (b == STAR_BYTE || b == PERCENT_BYTE) begin
        repeat ($urandom_range(2)) begin
          send_req(OP_NAME, pick_byte());
          produced++;
        end
      end else begin
        r = $urandom_range(99);
        if (r < 80) begin
          send_req(OP_NAME, $urandom_range(1) ? swap_case(b) : b);
        end else if (r < 90) begin
          send_req(OP_NAME, pick_byte());
        end
        produced++;
      end
    end
    if ($urandom_range(9) == 0) begin
      send_req(OP_NAME, pick_byte());
    end
    send_req(OP_END, BYTE_W'($urandom_range(255)));
  endtask

  task automatic random_sequence();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 10) begin
      repeat ($urandom_range(1, 4)) begin
        send_req(op_t'($urandom_range(3)), BYTE_W'($urandom_range(255)));
      end
    end else begin
      if ($urandom_range(99) < 85) begin
        send_req(OP_CLEAR, BYTE_W'($urandom_range(255)));
      end
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(5);
      end else if (r < 88) begin
        len = $urandom_range(6, 12);
      end else if (r < 96) begin
        len = $urandom_range(20, MAX_PATTERN);
      end else begin
        len = $urandom_range(MAX_PATTERN - 2, MAX_PATTERN + 6);
      end
      repeat (len) send_req(OP_APPEND, pick_byte());
      repeat ($urandom_range(1, 4)) send_name();
    end
  endtask

  task automatic run_directed();
    // Empty pattern against the empty name, then against a zero byte.
    send_req(OP_END, 8'h00);
    send_req(OP_NAME, 8'h00);
    send_req(OP_END, 8'hFF);
    // Upper-case pattern letter, percent, delimiter literal, trailing star.
    send_req(OP_CLEAR, 8'hFF);
    send_req(OP_APPEND, "A");
    send_req(OP_APPEND, PERCENT_BYTE);
    send_req(OP_APPEND, DELIM_RESET);
    send_req(OP_APPEND, STAR_BYTE);
    send_req(OP_NAME, "a");
    send_req(OP_NAME, 8'hFF);
    send_req(OP_NAME, DELIM_RESET);
    send_req(OP_NAME, "Y");
    send_req(OP_END, 8'h00);
    send_req(OP_NAME, "b");
    send_req(OP_END, 8'h00);
    // A percent next to a star acts as a star and crosses the delimiter.
    send_req(OP_CLEAR, 8'h00);
    send_req(OP_APPEND, PERCENT_BYTE);
    send_req(OP_APPEND, STAR_BYTE);
    send_req(OP_NAME, DELIM_RESET);
    send_req(OP_END, 8'h00);
    // A lone percent does not.
    send_req(OP_CLEAR, 8'h00);
    send_req(OP_APPEND, PERCENT_BYTE);
    send_req(OP_NAME, DELIM_RESET);
    send_req(OP_END, 8'h00);
  endtask

  initial begin
    logic [BYTE_W-1:0] delim_plan [SEGMENTS];
    int                s;
    delim_plan = '{8'h00, 8'hFF, "A", STAR_BYTE, "/", DELIM_RESET};
    rst                = 1;
    req_bus.valid      = 0;
    req_bus.action     = OP_CLEAR;
    req_bus.byte_value = '0;
    psel               = 0;
    penable            = 0;
    pwrite             = 0;
    paddr              = '0;
    pwdata             = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    run_directed();
    drain();
    for (s = 0; s < SEGMENTS; s++) begin
      if (s < 2) begin
        tx_idle_pct = 26;
        rx_idle_pct = 87;
      end else if (s < 4) begin
        tx_idle_pct = 87;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_delimiter(delim_plan[s]);
      if (s == HOLD_SEGMENT) begin
        // Keep offering end requests while results are held back.
        stall_armed = 1;
        repeat (30) send_req(OP_END, BYTE_W'($urandom_range(255)));
      end
      while (sent < 24 + RANDOM_ITEMS * (s + 1) / SEGMENTS) random_sequence();
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/mwm_pkg.sv
hdl/mwm_ifs.sv
hdl/mwm_front.sv
hdl/mwm_queue.sv
hdl/mwm_back.sv
hdl/mailbox_wildcard_matcher.sv
verif/testbench.sv
